// ----- hw/rtl/irpw_pkg.sv -----
// irpw_pkg: shared types and constants for the ir pulse-width command receiver
// no dependencies
package irpw_pkg;

    localparam int FRAME_BITS = 12;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int DEV_W      = 5;
    localparam int CMD_W      = 7;

    localparam logic [7:0] START_THR_RST = 8'd150;
    localparam logic [7:0] ONE_THR_RST   = 8'd70;
    localparam logic [4:0] SPEED_STEP_RST = 5'd31;

    localparam logic [1:0] REG_START_THR  = 2'd0;
    localparam logic [1:0] REG_ONE_THR    = 2'd1;
    localparam logic [1:0] REG_SPEED_STEP = 2'd2;

    localparam logic [CMD_W-1:0] CMD_LEVEL_MAX = 7'd7;
    localparam logic [CMD_W-1:0] CMD_STOP      = 7'd9;
    localparam logic [CMD_W-1:0] CMD_FASTER    = 7'd14;
    localparam logic [CMD_W-1:0] CMD_FORWARD   = 7'd16;
    localparam logic [CMD_W-1:0] CMD_REVERSE   = 7'd17;
    localparam logic [CMD_W-1:0] CMD_RIGHT     = 7'd18;
    localparam logic [CMD_W-1:0] CMD_LEFT      = 7'd19;
    localparam logic [CMD_W-1:0] CMD_ARM       = 7'd23;
    localparam logic [CMD_W-1:0] CMD_DISARM    = 7'd54;
    localparam logic [CMD_W-1:0] CMD_SLOWER    = 7'd63;
    localparam logic [CMD_W-1:0] CMD_FLIP      = 7'd96;
    localparam logic [CMD_W-1:0] CMD_DROP      = 7'd99;

    localparam logic [7:0] DRIVE_FORWARD = 8'hA0;
    localparam logic [7:0] DRIVE_REVERSE = 8'h50;
    localparam logic [7:0] DRIVE_LEFT    = 8'h60;
    localparam logic [7:0] DRIVE_RIGHT   = 8'h90;

    typedef struct packed {
        logic       line_level;
        logic [7:0] pulse_ticks;
    } t_in_item;

    typedef struct packed {
        logic             frame_done;
        logic [DEV_W-1:0] device_code;
        logic [CMD_W-1:0] command_code;
        logic [7:0]       drive_pattern;
        logic [7:0]       speed_duty;
        logic             sensor_enable;
        logic             flip_pulse;
        logic             drop_pulse;
    } t_out_item;

    typedef struct packed {
        logic             done;
        logic [DEV_W-1:0] device;
        logic [CMD_W-1:0] command;
    } t_frame_evt;

endpackage

// ----- hw/rtl/irpw_frame.sv -----
// irpw_frame: start detection and lsb-first bit collection into a frame
// depends on irpw_pkg
module irpw_frame import irpw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_in_item   i_item,
    input  logic [7:0] i_start_thr,
    input  logic [7:0] i_one_thr,
    output t_frame_evt o_evt
);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [FRAME_BITS-1:0] r_shift;
    logic [FRAME_BITS-1:0] n_shift;
    logic                  n_done;

    always_comb begin
        n_count = r_count;
        n_shift = r_shift;
        n_done  = 1'b0;
        if (i_item.line_level) begin
            if (i_item.pulse_ticks > i_start_thr) begin
                n_count = '0;
                n_shift = '0;
            end else if (r_count < CNT_W'(FRAME_BITS)) begin
                n_shift = {i_item.pulse_ticks > i_one_thr, r_shift[FRAME_BITS-1:1]};
                n_count = r_count + 1'b1;
                n_done  = (n_count == CNT_W'(FRAME_BITS));
            end
        end
    end

    assign o_evt.done    = n_done;
    assign o_evt.device  = n_shift[FRAME_BITS-1:FRAME_BITS-DEV_W];
    assign o_evt.command = n_shift[CMD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_shift <= '0;
        end else if (i_en) begin
            r_count <= n_count;
            r_shift <= n_shift;
        end
    end

endmodule

// ----- hw/rtl/irpw_cmd.sv -----
// irpw_cmd: command execution, holds last frame, drive, duty and sensor state
// depends on irpw_pkg
module irpw_cmd import irpw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_frame_evt i_evt,
    input  logic [4:0] i_speed_step,
    output t_out_item  o_result
);

    logic [DEV_W-1:0] r_device;
    logic [DEV_W-1:0] n_device;
    logic [CMD_W-1:0] r_command;
    logic [CMD_W-1:0] n_command;
    logic [7:0]       r_drive;
    logic [7:0]       n_drive;
    logic [7:0]       r_duty;
    logic [7:0]       n_duty;
    logic             r_armed;
    logic             n_armed;
    logic             n_flip;
    logic             n_drop;
    logic [8:0]       level_duty;
    logic [8:0]       up_duty;

    assign level_duty = ({1'b0, i_evt.command[2:0]} + 4'd1) * i_speed_step;
    assign up_duty    = {1'b0, r_duty} + {4'd0, i_speed_step};

    always_comb begin
        n_device  = r_device;
        n_command = r_command;
        n_drive   = r_drive;
        n_duty    = r_duty;
        n_armed   = r_armed;
        n_flip    = 1'b0;
        n_drop    = 1'b0;
        if (i_evt.done) begin
            n_device  = i_evt.device;
            n_command = i_evt.command;
            if (i_evt.command <= CMD_LEVEL_MAX) begin
                n_duty = level_duty[7:0];
            end else begin
                case (i_evt.command)
                    CMD_FORWARD: n_drive = DRIVE_FORWARD;
                    CMD_REVERSE: n_drive = DRIVE_REVERSE;
                    CMD_LEFT:    n_drive = DRIVE_LEFT;
                    CMD_RIGHT:   n_drive = DRIVE_RIGHT;
                    CMD_STOP:    n_duty  = '0;
                    CMD_FASTER: begin
                        if (!up_duty[8]) n_duty = up_duty[7:0];
                    end
                    CMD_SLOWER: begin
                        if (r_duty >= {3'd0, i_speed_step}) n_duty = r_duty - {3'd0, i_speed_step};
                    end
                    CMD_ARM:     n_armed = 1'b1;
                    CMD_DISARM:  n_armed = 1'b0;
                    CMD_FLIP:    n_flip  = 1'b1;
                    CMD_DROP:    n_drop  = 1'b1;
                    default:     ;
                endcase
            end
        end
    end

    assign o_result.frame_done    = i_evt.done;
    assign o_result.device_code   = n_device;
    assign o_result.command_code  = n_command;
    assign o_result.drive_pattern = n_drive;
    assign o_result.speed_duty    = n_duty;
    assign o_result.sensor_enable = n_armed;
    assign o_result.flip_pulse    = n_flip;
    assign o_result.drop_pulse    = n_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device  <= '0;
            r_command <= '0;
            r_drive   <= '0;
            r_duty    <= '0;
            r_armed   <= 1'b0;
        end else if (i_en) begin
            r_device  <= n_device;
            r_command <= n_command;
            r_drive   <= n_drive;
            r_duty    <= n_duty;
            r_armed   <= n_armed;
        end
    end

endmodule

// ----- hw/rtl/ir_pulse_width_command_receiver.sv -----
// ir_pulse_width_command_receiver: top level with input register, config registers,
// frame collector, command unit and result register; depends on irpw_pkg
// data path: input register, then frame and command logic, then result register
// throughput: one edge item per cycle unless output stalls, set by the single input-to-result stage
// reset: synchronous active-low; thresholds and step to defaults, frame and
// command state to zero, both pipeline registers empty
module ir_pulse_width_command_receiver import irpw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic [7:0] r_start_thr;
    logic [7:0] r_one_thr;
    logic [4:0] r_speed_step;
    logic       advance;
    t_frame_evt frame_evt;
    t_out_item  result;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_thr  <= START_THR_RST;
            r_one_thr    <= ONE_THR_RST;
            r_speed_step <= SPEED_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_THR:  r_start_thr  <= i_cfg_data;
                REG_ONE_THR:    r_one_thr    <= i_cfg_data;
                REG_SPEED_STEP: r_speed_step <= i_cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    irpw_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_item      (r_in),
        .i_start_thr (r_start_thr),
        .i_one_thr   (r_one_thr),
        .o_evt       (frame_evt)
    );

    irpw_cmd u_cmd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_evt        (frame_evt),
        .i_speed_step (r_speed_step),
        .o_result     (result)
    );

    a_pulse_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.flip_pulse || r_out.drop_pulse) |-> r_out.frame_done)
        else $error("command pulse without completed frame");

    a_pulse_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.flip_pulse && r_out.drop_pulse))
        else $error("flip and drop pulses together");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_in))
        else $error("held input item lost");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for ir_pulse_width_command_receiver: edge items in, decoder state out,
// checked against an in-file decoder model under several register settings
// depends on irpw_pkg and the receiver rtl
module testbench;
    import irpw_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_PRINTS     = 100;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       o_cfg_ready;

    ir_pulse_width_command_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow registers
    logic [7:0] thr_start = START_THR_RST;
    logic [7:0] thr_one   = ONE_THR_RST;
    logic [4:0] step      = SPEED_STEP_RST;

    // decoder state
    logic [CNT_W-1:0]      frm_count = '0;
    logic [FRAME_BITS-1:0] frm_shift = '0;
    logic [DEV_W-1:0]      frm_dev   = '0;
    logic [CMD_W-1:0]      frm_cmd   = '0;
    logic [7:0]            drive_now = '0;
    logic [7:0]            duty_now  = '0;
    logic                  armed_now = 1'b0;

    t_in_item  edge_backlog[$];
    t_out_item awaited_results[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic in_took = 1'b0;
    int  errors = 0;
    int  stuck = 0;
    int  n_edges = 0;
    int  n_results = 0;
    int  n_frames = 0;
    int  n_cfg_writes = 0;
    int  queued_edges = 0;

    function automatic t_out_item decode_edge(t_in_item e);
        t_out_item r;
        r = '0;
        if (e.line_level) begin
            if (e.pulse_ticks > thr_start) begin
                frm_count = '0;
                frm_shift = '0;
            end else if (frm_count < FRAME_BITS) begin
                frm_shift = {e.pulse_ticks > thr_one, frm_shift[FRAME_BITS-1:1]};
                frm_count = frm_count + 1'b1;
                if (frm_count == FRAME_BITS) begin
                    r.frame_done = 1'b1;
                    n_frames++;
                    frm_dev = frm_shift[FRAME_BITS-1:CMD_W];
                    frm_cmd = frm_shift[CMD_W-1:0];
                    if (frm_cmd <= CMD_LEVEL_MAX) begin
                        duty_now = 8'((int'(frm_cmd) + 1) * int'(step));
                    end else begin
                        case (frm_cmd)
                            CMD_FORWARD: drive_now = DRIVE_FORWARD;
                            CMD_REVERSE: drive_now = DRIVE_REVERSE;
                            CMD_LEFT:    drive_now = DRIVE_LEFT;
                            CMD_RIGHT:   drive_now = DRIVE_RIGHT;
                            CMD_STOP:    duty_now = '0;
                            CMD_FASTER: begin
                                if (int'(duty_now) + int'(step) <= 255)
                                    duty_now = duty_now + step;
                            end
                            CMD_SLOWER: begin
                                if (duty_now >= step)
                                    duty_now = duty_now - step;
                            end
                            CMD_ARM:     armed_now = 1'b1;
                            CMD_DISARM:  armed_now = 1'b0;
                            CMD_FLIP:    r.flip_pulse = 1'b1;
                            CMD_DROP:    r.drop_pulse = 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
        end
        r.device_code   = frm_dev;
        r.command_code  = frm_cmd;
        r.drive_pattern = drive_now;
        r.speed_duty    = duty_now;
        r.sensor_enable = armed_now;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at result %0d: %s", n_results, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (edge_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item  <= edge_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor: sample on the rising edge
    always @(posedge clk) begin
        t_out_item want;
        in_took <= rst_n && in_valid && !o_in_stall;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                awaited_results.push_back(decode_edge(in_item));
                n_edges++;
            end
            if (o_out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no item pending");
                end else begin
                    want = awaited_results.pop_front();
                    check_field("frame_done", 8'(o_out_item.frame_done), 8'(want.frame_done));
                    check_field("device_code", 8'(o_out_item.device_code),
                                8'(want.device_code));
                    check_field("command_code", 8'(o_out_item.command_code),
                                8'(want.command_code));
                    check_field("drive_pattern", o_out_item.drive_pattern, want.drive_pattern);
                    check_field("speed_duty", o_out_item.speed_duty, want.speed_duty);
                    check_field("sensor_enable", 8'(o_out_item.sensor_enable),
                                8'(want.sensor_enable));
                    check_field("flip_pulse", 8'(o_out_item.flip_pulse), 8'(want.flip_pulse));
                    check_field("drop_pulse", 8'(o_out_item.drop_pulse), 8'(want.drop_pulse));
                end
                n_results++;
            end
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
            if (stuck >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d results outstanding", awaited_results.size());
                $display("[ir_pulse_width_command_receiver] ERROR");
                $finish;
            end
        end
    end

    task automatic push_edge(logic level, logic [7:0] ticks);
        t_in_item e;
        e.line_level  = level;
        e.pulse_ticks = ticks;
        edge_backlog.push_back(e);
        queued_edges++;
    endtask

    function automatic logic [7:0] zero_ticks();
        int hi;
        hi = (thr_one < thr_start) ? int'(thr_one) : int'(thr_start);
        if ($urandom_range(0, 7) == 0)
            return 8'(hi);
        return 8'($urandom_range(0, hi));
    endfunction

    function automatic logic [7:0] one_ticks();
        if (thr_one >= thr_start)
            return zero_ticks();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? thr_start : thr_one + 8'd1;
        return 8'($urandom_range(int'(thr_one) + 1, int'(thr_start)));
    endfunction

    function automatic logic [7:0] start_ticks();
        if (thr_start == 8'hFF)
            return 8'hFF;
        return 8'($urandom_range(int'(thr_start) + 1, 255));
    endfunction

    // start pulse, then nbits data bits lsb first; bits past the word are random
    task automatic queue_frame(logic [FRAME_BITS-1:0] word, int nbits);
        logic b;
        push_edge(1'b1, start_ticks());
        for (int i = 0; i < nbits; i++) begin
            b = (i < FRAME_BITS) ? word[i] : 1'($urandom);
            if ($urandom_range(0, 1) != 0)
                push_edge(1'b0, 8'($urandom));
            push_edge(1'b1, b ? one_ticks() : zero_ticks());
        end
    endtask

    function automatic logic [CMD_W-1:0] pick_command();
        case ($urandom_range(0, 15))
            0:  return CMD_STOP;
            1:  return CMD_FASTER;
            2:  return CMD_FORWARD;
            3:  return CMD_REVERSE;
            4:  return CMD_RIGHT;
            5:  return CMD_LEFT;
            6:  return CMD_ARM;
            7:  return CMD_DISARM;
            8:  return CMD_SLOWER;
            9:  return CMD_FLIP;
            10: return CMD_DROP;
            11: return 7'($urandom_range(0, int'(CMD_LEVEL_MAX)));
            12: return CMD_FASTER;
            13: return CMD_SLOWER;
            default: return 7'($urandom);
        endcase
    endfunction

    task automatic fill_block(int n);
        int target;
        int r;
        target = queued_edges + n;
        while (queued_edges < target) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                queue_frame({5'($urandom), pick_command()}, FRAME_BITS);
            else if (r < 80)
                queue_frame(12'($urandom), $urandom_range(1, FRAME_BITS - 1));
            else if (r < 90)
                queue_frame({5'($urandom), pick_command()}, $urandom_range(13, 16));
            else
                repeat ($urandom_range(1, 6)) push_edge(1'($urandom), 8'($urandom));
        end
    endtask

    task automatic queue_directed();
        logic [FRAME_BITS-1:0] word;
        word = {5'h1F, CMD_FORWARD};
        push_edge(1'b0, 8'hFF);
        push_edge(1'b0, 8'h00);
        push_edge(1'b1, 8'h00);
        push_edge(1'b1, 8'hFF);
        for (int i = 0; i < FRAME_BITS; i++) begin
            if (word[i])
                push_edge(1'b1, i[0] ? thr_start : thr_one + 8'd1);
            else
                push_edge(1'b1, i[0] ? thr_one : 8'h00);
        end
        push_edge(1'b1, thr_start);
        push_edge(1'b1, thr_one + 8'd1);
        push_edge(1'b1, thr_start + 8'd1);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        case (idx)
            REG_START_THR:  thr_start = data;
            REG_ONE_THR:    thr_one = data;
            REG_SPEED_STEP: step = data[4:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (edge_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(int k);
        int s;
        int o;
        int st;
        case (k)
            1: begin s = 200; o = 100; st = 1; end
            2: begin s = 255; o = 0; st = 0; end
            3: begin s = 0; o = 255; st = 31; end
            4: begin s = int'(START_THR_RST); o = int'(ONE_THR_RST); st = int'(SPEED_STEP_RST); end
            default: begin
                s = $urandom_range(90, 255);
                o = $urandom_range(10, s - 1);
                st = $urandom_range(0, 31);
            end
        endcase
        cfg_write(REG_START_THR, 8'(s));
        cfg_write(REG_ONE_THR, 8'(o));
        cfg_write(REG_SPEED_STEP, {3'($urandom), 5'(st)});
        if (k == 5)
            cfg_write(REG_UNUSED, 8'($urandom));
    endtask

    initial begin
        int k;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 50 : 0;
            recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 19 : 0;
            for (int b = 0; b < 4; b++) begin
                k = ph * 4 + b;
                if (k != 0) begin
                    settle();
                    apply_setting(k);
                end else begin
                    queue_directed();
                end
                fill_block((k == 2 || k == 3) ? 40 : 135);
            end
        end
        settle();
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        $display("covered %0d edge items, %0d results, %0d decoded frames, %0d register writes",
                 n_edges, n_results, n_frames, n_cfg_writes);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("[ir_pulse_width_command_receiver] OK");
        else
            $display("[ir_pulse_width_command_receiver] ERROR");
        $finish;
    end

endmodule
